>>> hdl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned BLK_W     = 17;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 2;

  // Configuration reset values.
  localparam logic [DATA_W-1:0]    BASE_RST        = 32'd0;
  localparam logic [BLK_W-1:0]     BLOCK_BYTES_RST = 17'd64;
  localparam logic [DATA_W-1:0]    POOL_BYTES_RST  = 32'd65536;
  localparam logic [CNT_OUT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REFILL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_BLOCK_BYTES  = 2'd1,
    CFG_POOL_BYTES   = 2'd2,
    CFG_BLOCK_COUNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_FILL = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic imm_resp;    // finish a free, a failed allocation or an unknown mode now
    logic pop_start;   // issue the stack read for an allocation
    logic pop_done;    // read data is back: finish the allocation
    logic fill_start;  // begin a refill walk
    logic fill_step;   // write one refill entry
    logic fill_done;   // close the refill
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stack_nonempty;
    logic fill_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/fbpa_in_if.sv
`default_nettype none

interface fbpa_in_if;
  logic                           valid;
  logic                           ready;
  logic [fbpa_pkg::MODE_W-1:0]    mode;
  logic [fbpa_pkg::DATA_W-1:0]    free_address;

  modport source (output valid, output mode, output free_address, input ready);
  modport sink (input valid, input mode, input free_address, output ready);
endinterface

`default_nettype wire

>>> hdl/fbpa_out_if.sv
`default_nettype none

interface fbpa_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [fbpa_pkg::DATA_W-1:0]    block_address;
  logic [fbpa_pkg::CNT_OUT_W-1:0] avail_count;
  logic [fbpa_pkg::CNT_OUT_W-1:0] taken_count;
  logic [fbpa_pkg::DATA_W-1:0]    alloc_total;
  logic [fbpa_pkg::DATA_W-1:0]    free_total;
  logic [fbpa_pkg::DATA_W-1:0]    peak_used_bytes;

  modport source (
    output valid, output ok, output block_address, output avail_count,
    output taken_count, output alloc_total, output free_total,
    output peak_used_bytes, input ready
  );
  modport sink (
    input valid, input ok, input block_address, input avail_count,
    input taken_count, input alloc_total, input free_total,
    input peak_used_bytes, output ready
  );
endinterface

`default_nettype wire

>>> hdl/fixed_block_pool_allocator.sv
`default_nettype none

// Channel   Direction  Transaction carries
// in_i      sink       mode, free_address
// out_o     source     ok, block_address, avail_count, taken_count,
//                      alloc_total, free_total, peak_used_bytes
// cfg_*     write      cfg_index_i selects the register, cfg_wdata_i holds the value
//
// A free, a failed allocation or an unknown mode gives its result in the cycle after
// acceptance; a successful allocation passes through the pop state for the registered
// stack read; a refill passes through the fill state, one stack write per block.
// A new item is taken in the same cycle that the previous result is taken.
// Reset empties the stack and clears all counters; no clearing pass is needed.
// A stalled result holds its fields, and no item is accepted until it is taken.

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fbpa_pkg::DATA_W-1:0]    cfg_wdata_i,
  fbpa_in_if.sink                             in_i,
  fbpa_out_if.source                          out_o
);

  fbpa_pkg::dp_cmd_t    cmd;
  fbpa_pkg::dp_status_t status;
  fbpa_pkg::mode_e      mode;

  assign mode = fbpa_pkg::mode_e'(in_i.mode);

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .mode_i      (mode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode),
    .free_address_i    (in_i.free_address),
    .cmd_i             (cmd),
    .status_o          (status),
    .ok_o              (out_o.ok),
    .block_address_o   (out_o.block_address),
    .avail_count_o     (out_o.avail_count),
    .taken_count_o     (out_o.taken_count),
    .alloc_total_o     (out_o.alloc_total),
    .free_total_o      (out_o.free_total),
    .peak_used_bytes_o (out_o.peak_used_bytes)
  );

endmodule

`default_nettype wire

>>> hdl/fbpa_ram.sv
`default_nettype none

module fbpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/fbpa_ctrl.sv
`default_nettype none

module fbpa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire fbpa_pkg::mode_e      mode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire fbpa_pkg::dp_status_t status_i,
  output fbpa_pkg::dp_cmd_t         cmd_o
);

  fbpa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;
  logic             load;

  // The result slot is free when empty or being taken in this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == fbpa_pkg::ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    load    = 1'b0;
    case (state_q)
      fbpa_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            fbpa_pkg::MODE_ALLOC: begin
              if (status_i.stack_nonempty) begin
                cmd_o.pop_start = 1'b1;
                state_d         = fbpa_pkg::ST_POP;
              end else begin
                cmd_o.imm_resp = 1'b1;
                load           = 1'b1;
              end
            end
            fbpa_pkg::MODE_REFILL: begin
              cmd_o.fill_start = 1'b1;
              state_d          = fbpa_pkg::ST_FILL;
            end
            default: begin
              cmd_o.imm_resp = 1'b1;
              load           = 1'b1;
            end
          endcase
        end
      end
      fbpa_pkg::ST_POP: begin
        cmd_o.pop_done = 1'b1;
        load           = 1'b1;
        state_d        = fbpa_pkg::ST_IDLE;
      end
      fbpa_pkg::ST_FILL: begin
        if (status_i.fill_last) begin
          cmd_o.fill_done = 1'b1;
          load            = 1'b1;
          state_d         = fbpa_pkg::ST_IDLE;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      default: begin
        state_d = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Result valid: set on a load, cleared when the transaction completes.
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pop or a refill only runs while the result slot is empty.
  a_busy_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fbpa_pkg::ST_IDLE) |-> !out_valid_q)
    else $error("result pending during a pop or refill");

  // At most one datapath command per cycle.
  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

  // A started pop completes in the next cycle.
  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_start |=> cmd_o.pop_done)
    else $error("pop did not complete");

endmodule

`default_nettype wire

>>> hdl/fbpa_datapath.sv
`default_nettype none

module fbpa_datapath #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [fbpa_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  wire fbpa_pkg::mode_e                    mode_i,
  input  wire logic [fbpa_pkg::DATA_W-1:0]        free_address_i,
  input  wire fbpa_pkg::dp_cmd_t                  cmd_i,
  output fbpa_pkg::dp_status_t                    status_o,
  output logic                                    ok_o,
  output logic      [fbpa_pkg::DATA_W-1:0]        block_address_o,
  output logic      [fbpa_pkg::CNT_OUT_W-1:0]     avail_count_o,
  output logic      [fbpa_pkg::CNT_OUT_W-1:0]     taken_count_o,
  output logic      [fbpa_pkg::DATA_W-1:0]        alloc_total_o,
  output logic      [fbpa_pkg::DATA_W-1:0]        free_total_o,
  output logic      [fbpa_pkg::DATA_W-1:0]        peak_used_bytes_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CMP_W = 64;
  localparam int unsigned DW    = fbpa_pkg::DATA_W;
  localparam int unsigned BW    = fbpa_pkg::BLK_W;
  localparam int unsigned CW    = fbpa_pkg::CNT_OUT_W;

  // Configuration registers.
  logic [DW-1:0] base_q;
  logic [BW-1:0] bb_q;
  logic [DW-1:0] pool_q;
  logic [CW-1:0] bc_q;

  // Pool state and statistics.
  logic [CNT_W-1:0] stack_q, stack_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [DW-1:0]    ubt_q, ubt_d;
  logic [DW-1:0]    alloc_q, alloc_d;
  logic [DW-1:0]    freec_q, freec_d;
  logic [DW-1:0]    peak_q, peak_d;
  logic [CNT_W-1:0] fill_idx_q, fill_idx_d;
  logic [ADDR_WIDTH-1:0] acc_q, acc_d;
  logic          ok_q, ok_d;
  logic [DW-1:0] addr_q, addr_d;

  logic [CNT_W-1:0]      n_eff;
  logic [ADDR_WIDTH-1:0] a_m;
  logic [ADDR_WIDTH-1:0] b_m;
  logic [ADDR_WIDTH-1:0] a_off;
  logic                  in_pool;
  logic                  room;
  logic                  push;
  logic [DW:0]           ubt_sum;
  logic [DW-1:0]         ubt_add;
  logic [DW-1:0]         ubt_sub;
  logic [CNT_W-1:0]      stack_dec;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ADDR_WIDTH-1:0] ram_wdata;
  logic [ADDR_WIDTH-1:0] ram_rdata;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fbpa_pkg::BASE_RST;
      bb_q   <= fbpa_pkg::BLOCK_BYTES_RST;
      pool_q <= fbpa_pkg::POOL_BYTES_RST;
      bc_q   <= fbpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (fbpa_pkg::cfg_idx_e'(cfg_index_i))
        fbpa_pkg::CFG_BASE_ADDRESS: base_q <= cfg_wdata_i;
        fbpa_pkg::CFG_BLOCK_BYTES:  bb_q   <= cfg_wdata_i[BW-1:0];
        fbpa_pkg::CFG_POOL_BYTES:   pool_q <= cfg_wdata_i;
        fbpa_pkg::CFG_BLOCK_COUNT:  bc_q   <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Effective block count saturates at the stack depth.
  always_comb begin
    if (CMP_W'(bc_q) > CMP_W'(MAX_BLOCKS)) begin
      n_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      n_eff = CNT_W'(bc_q);
    end
  end

  // Containment check on addresses taken modulo the address width.
  assign a_m     = ADDR_WIDTH'(free_address_i);
  assign b_m     = ADDR_WIDTH'(base_q);
  assign a_off   = a_m - b_m;
  assign in_pool = (a_m >= b_m) && (CMP_W'(a_off) < CMP_W'(pool_q));
  assign room    = stack_q < n_eff;
  assign push    = cmd_i.imm_resp && (mode_i == fbpa_pkg::MODE_FREE) && in_pool && room;

  // Used-byte arithmetic, saturating at both ends.
  assign ubt_sum = {1'b0, ubt_q} + (DW + 1)'(bb_q);
  assign ubt_add = ubt_sum[DW] ? '1 : ubt_sum[DW-1:0];
  assign ubt_sub = ((DW + 1)'(ubt_q) > (DW + 1)'(bb_q)) ? (ubt_q - DW'(bb_q)) : '0;

  assign stack_dec = stack_q - CNT_W'(1);

  // State update for each command.
  always_comb begin
    stack_d    = stack_q;
    used_d     = used_q;
    ubt_d      = ubt_q;
    alloc_d    = alloc_q;
    freec_d    = freec_q;
    peak_d     = peak_q;
    fill_idx_d = fill_idx_q;
    acc_d      = acc_q;
    ok_d       = ok_q;
    addr_d     = addr_q;
    if (cmd_i.imm_resp) begin
      ok_d   = push;
      addr_d = '0;
      if (push) begin
        stack_d = stack_q + CNT_W'(1);
        used_d  = (used_q != '0) ? (used_q - CNT_W'(1)) : '0;
        ubt_d   = ubt_sub;
        freec_d = freec_q + DW'(1);
      end
    end
    if (cmd_i.pop_done) begin
      ok_d    = 1'b1;
      addr_d  = DW'(ram_rdata);
      stack_d = stack_dec;
      used_d  = (used_q < CNT_W'(MAX_BLOCKS)) ? (used_q + CNT_W'(1)) : used_q;
      ubt_d   = ubt_add;
      alloc_d = alloc_q + DW'(1);
      if (ubt_add > peak_q) begin
        peak_d = ubt_add;
      end
    end
    if (cmd_i.fill_start) begin
      fill_idx_d = '0;
      acc_d      = b_m;
    end
    if (cmd_i.fill_step) begin
      fill_idx_d = fill_idx_q + CNT_W'(1);
      acc_d      = acc_q + ADDR_WIDTH'(bb_q);
    end
    if (cmd_i.fill_done) begin
      stack_d = n_eff;
      used_d  = '0;
      ubt_d   = '0;
      ok_d    = 1'b1;
      addr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q    <= '0;
      used_q     <= '0;
      ubt_q      <= '0;
      alloc_q    <= '0;
      freec_q    <= '0;
      peak_q     <= '0;
      fill_idx_q <= '0;
    end else begin
      stack_q    <= stack_d;
      used_q     <= used_d;
      ubt_q      <= ubt_d;
      alloc_q    <= alloc_d;
      freec_q    <= freec_d;
      peak_q     <= peak_d;
      fill_idx_q <= fill_idx_d;
    end
  end

  // Result payload and refill address accumulator.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ok_q   <= ok_d;
    addr_q <= addr_d;
  end

  // Free stack: pushes and refill writes share the write port.
  assign ram_we    = push || cmd_i.fill_step;
  assign ram_waddr = cmd_i.fill_step ? fill_idx_q[IDX_W-1:0] : stack_q[IDX_W-1:0];
  assign ram_wdata = cmd_i.fill_step ? acc_q : a_m;

  fbpa_ram #(
    .WIDTH (ADDR_WIDTH),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pop_start),
    .raddr_i (stack_dec[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.stack_nonempty = (stack_q != '0);
  assign status_o.fill_last      = (fill_idx_q == n_eff);

  assign ok_o              = ok_q;
  assign block_address_o   = addr_q;
  assign avail_count_o     = CW'(stack_q);
  assign taken_count_o     = CW'(used_q);
  assign alloc_total_o     = alloc_q;
  assign free_total_o      = freec_q;
  assign peak_used_bytes_o = peak_q;

  // The stack never holds more entries than it has room for.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(stack_q) <= CMP_W'(MAX_BLOCKS))
    else $error("stack count beyond depth");

  // The peak tracks the used byte count from above.
  a_peak_ge_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= ubt_q)
    else $error("peak below used bytes");

  // A pop never overlaps a stack write.
  a_pop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> !ram_we)
    else $error("stack written while a pop completes");

endmodule

`default_nettype wire

>>> verif/fixed_block_pool_allocator_test.sv
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam int unsigned POOL_DEPTH = 1024;
  localparam int          MAX_GAP    = 16;
  localparam int          MAX_STALL  = 16;
  localparam int          NUM_PHASES = 8;
  localparam int          PHASE_ITEMS = 206;

  // One result transaction of the allocator.
  typedef struct {
    logic                 ok;
    logic [DATA_W-1:0]    block_address;
    logic [CNT_OUT_W-1:0] avail_count;
    logic [CNT_OUT_W-1:0] taken_count;
    logic [DATA_W-1:0]    alloc_total;
    logic [DATA_W-1:0]    free_total;
    logic [DATA_W-1:0]    peak_used_bytes;
  } pool_reply_t;

  // Tracks the pool state, predicts each reply and compares the replies that come back.
  class pool_tracker;
    logic [DATA_W-1:0]    base_q;
    logic [BLK_W-1:0]     blk_q;
    logic [DATA_W-1:0]    pool_q;
    logic [CNT_OUT_W-1:0] count_q;
    logic [DATA_W-1:0]    shadow_stack [POOL_DEPTH];
    int unsigned          depth;
    int unsigned          used;
    logic [DATA_W-1:0]    used_bytes;
    logic [DATA_W-1:0]    allocs;
    logic [DATA_W-1:0]    frees;
    logic [DATA_W-1:0]    peak;
    pool_reply_t          pending_replies [$];
    logic [DATA_W-1:0]    handed_out [$];
    int unsigned          errors;
    int unsigned          replies_checked;
    int unsigned          n_alloc_ok;
    int unsigned          n_alloc_fail;
    int unsigned          n_free_ok;
    int unsigned          n_free_refused;
    int unsigned          n_refill;
    int unsigned          n_unknown;

    function new();
      base_q     = BASE_RST;
      blk_q      = BLOCK_BYTES_RST;
      pool_q     = POOL_BYTES_RST;
      count_q    = BLOCK_COUNT_RST;
      depth      = 0;
      used       = 0;
      used_bytes = '0;
      allocs     = '0;
      frees      = '0;
      peak       = '0;
      errors     = 0;
      replies_checked = 0;
      n_alloc_ok = 0;
      n_alloc_fail = 0;
      n_free_ok  = 0;
      n_free_refused = 0;
      n_refill   = 0;
      n_unknown  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_BASE_ADDRESS: base_q  = value;
        CFG_BLOCK_BYTES:  blk_q   = value[BLK_W-1:0];
        CFG_POOL_BYTES:   pool_q  = value;
        CFG_BLOCK_COUNT:  count_q = value[CNT_OUT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_blocks();
      return (count_q > POOL_DEPTH) ? POOL_DEPTH : int'(count_q);
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    // Applies one accepted request to the pool state and queues the reply it must produce.
    function void predict_reply(mode_e m, logic [DATA_W-1:0] a);
      pool_reply_t     r;
      logic [DATA_W:0] sum;
      int unsigned     n;
      r.ok = 1'b0;
      r.block_address = '0;
      case (m)
        MODE_ALLOC: begin
          if (depth > 0) begin
            depth--;
            r.block_address = shadow_stack[depth];
            r.ok = 1'b1;
            if (used < POOL_DEPTH) used++;
            sum = {1'b0, used_bytes} + {{(DATA_W + 1 - BLK_W){1'b0}}, blk_q};
            used_bytes = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            allocs++;
            if (used_bytes > peak) peak = used_bytes;
            handed_out.push_back(r.block_address);
            n_alloc_ok++;
          end else begin
            n_alloc_fail++;
          end
        end
        MODE_FREE: begin
          if ((a >= base_q) && ((a - base_q) < pool_q) && (depth < eff_blocks())) begin
            shadow_stack[depth] = a;
            depth++;
            r.ok = 1'b1;
            if (used > 0) used--;
            used_bytes = (used_bytes > blk_q) ? used_bytes - blk_q : '0;
            frees++;
            n_free_ok++;
          end else begin
            n_free_refused++;
          end
        end
        MODE_REFILL: begin
          n = eff_blocks();
          for (int unsigned i = 0; i < n; i++) shadow_stack[i] = base_q + i * blk_q;
          depth = n;
          used = 0;
          used_bytes = '0;
          r.ok = 1'b1;
          handed_out.delete();
          n_refill++;
        end
        default: n_unknown++;
      endcase
      r.avail_count     = depth[CNT_OUT_W-1:0];
      r.taken_count     = used[CNT_OUT_W-1:0];
      r.alloc_total     = allocs;
      r.free_total      = frees;
      r.peak_used_bytes = peak;
      pending_replies.push_back(r);
    endfunction

    // Compares one accepted reply with the oldest prediction.
    function void check_reply(pool_reply_t got);
      pool_reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("Reply transaction with no request outstanding");
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      replies_checked++;
      if (got.ok !== exp_r.ok) begin
        $error("ok: expected %0d, got %0d", exp_r.ok, got.ok);
        errors++;
      end
      if (got.block_address !== exp_r.block_address) begin
        $error("block_address: expected %h, got %h", exp_r.block_address, got.block_address);
        errors++;
      end
      if (got.avail_count !== exp_r.avail_count) begin
        $error("avail_count: expected %0d, got %0d", exp_r.avail_count, got.avail_count);
        errors++;
      end
      if (got.taken_count !== exp_r.taken_count) begin
        $error("taken_count: expected %0d, got %0d", exp_r.taken_count, got.taken_count);
        errors++;
      end
      if (got.alloc_total !== exp_r.alloc_total) begin
        $error("alloc_total: expected %0d, got %0d", exp_r.alloc_total, got.alloc_total);
        errors++;
      end
      if (got.free_total !== exp_r.free_total) begin
        $error("free_total: expected %0d, got %0d", exp_r.free_total, got.free_total);
        errors++;
      end
      if (got.peak_used_bytes !== exp_r.peak_used_bytes) begin
        $error("peak_used_bytes: expected %0d, got %0d", exp_r.peak_used_bytes,
               got.peak_used_bytes);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_wdata_i;

  fbpa_in_if  in_bus ();
  fbpa_out_if out_bus ();

  fixed_block_pool_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  pool_tracker tracker;
  int          send_gap_pct;
  int          recv_stall_pct;
  longint      cycle_count;
  longint      cycle_limit;
  int unsigned items_sent;

  // Free-running clock with a 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog: the budget grows with every request that is driven.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $error("Timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then choose ready for the next cycle.
  initial begin : reply_sink
    int          stall_run;
    pool_reply_t got;
    stall_run = 0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.ok              = out_bus.ok;
        got.block_address   = out_bus.block_address;
        got.avail_count     = out_bus.avail_count;
        got.taken_count     = out_bus.taken_count;
        got.alloc_total     = out_bus.alloc_total;
        got.free_total      = out_bus.free_total;
        got.peak_used_bytes = out_bus.peak_used_bytes;
        tracker.check_reply(got);
      end
      if (recv_stall_pct != 0 && stall_run < MAX_STALL &&
          $urandom_range(99) < recv_stall_pct) begin
        out_bus.ready <= 1'b0;
        stall_run++;
      end else begin
        out_bus.ready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  // Drives one request and returns at the edge where it is accepted, with valid still high.
  task automatic send_item(input mode_e m, input logic [DATA_W-1:0] a);
    int gap;
    gap = 0;
    while (send_gap_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      gap++;
      @(posedge clk_i);
    end
    cycle_limit += 4 * (MAX_GAP + MAX_STALL + 8 +
                        ((m == MODE_REFILL) ? tracker.eff_blocks() : 0));
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= m;
    in_bus.free_address <= a;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    tracker.predict_reply(m, a);
    items_sent++;
  endtask

  // Lowers valid and waits until every outstanding reply has been taken.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive edges while the block is idle.
  task automatic apply_config(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] blk,
                              input logic [DATA_W-1:0] pool, input logic [DATA_W-1:0] cnt);
    cfg_idx_e          idx [4];
    logic [DATA_W-1:0] val [4];
    idx = '{CFG_BASE_ADDRESS, CFG_BLOCK_BYTES, CFG_POOL_BYTES, CFG_BLOCK_COUNT};
    val = '{base, blk, pool, cnt};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Picks a pool layout for one random phase; the first two phases take the extremes.
  task automatic phase_config(input int phase);
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] blk;
    logic [DATA_W-1:0] pool;
    logic [DATA_W-1:0] cnt;
    longint unsigned   span;
    if (phase == 0) begin
      base = 32'hFFFF_0000; blk = 32'd65536; pool = 32'hFFFF_FFFF; cnt = 32'd1024;
    end else if (phase == 1) begin
      base = 32'd0; blk = 32'd1; pool = 32'd1; cnt = 32'd1;
    end else begin
      case ($urandom_range(3))
        0: cnt = 32'd1;
        1: cnt = 32'd1024;
        default: cnt = $urandom_range(48, 2);
      endcase
      case ($urandom_range(3))
        0: blk = 32'd1;
        1: blk = 32'd65536;
        2: blk = 32'd1 << $urandom_range(12);
        default: blk = $urandom_range(65536, 1);
      endcase
      case ($urandom_range(3))
        0: base = 32'd0;
        1: base = 32'hFFFF_FFFF - $urandom_range(4095);
        2: base = $urandom & 32'hFFFF_F000;
        default: base = $urandom;
      endcase
      span = longint'(cnt) * longint'(blk);
      case ($urandom_range(7))
        0: pool = 32'd1;
        1: pool = 32'hFFFF_FFFF;
        2: pool = $urandom_range(32'hFFFF_FFFF, 1);
        default: pool = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[DATA_W-1:0];
      endcase
    end
    apply_config(base, blk, pool, cnt);
  endtask

  // Mostly allocations and frees of handed-out blocks, with stray frees and other modes.
  task automatic random_item();
    int unsigned       r;
    int unsigned       s;
    int unsigned       idx;
    mode_e             m;
    logic [DATA_W-1:0] a;
    r = $urandom_range(99);
    a = $urandom;
    if (r < 3 || (tracker.depth == 0 && tracker.handed_out.size() == 0 &&
                  $urandom_range(3) == 0)) begin
      m = MODE_REFILL;
    end else if (r < 6) begin
      m = MODE_NONE;
    end else if (r < 50) begin
      m = MODE_ALLOC;
    end else begin
      m = MODE_FREE;
      s = $urandom_range(99);
      if (s < 70 && tracker.handed_out.size() > 0) begin
        idx = $urandom_range(tracker.handed_out.size() - 1);
        a = tracker.handed_out[idx];
        tracker.handed_out.delete(idx);
      end else if (s < 85) begin
        a = tracker.base_q + ($urandom % tracker.pool_q);
      end else if (s < 92) begin
        case ($urandom_range(2))
          0: a = tracker.base_q - 32'd1;
          1: a = tracker.base_q + tracker.pool_q;
          default: a = tracker.base_q + tracker.pool_q - 32'd1;
        endcase
      end
    end
    send_item(m, a);
  endtask

  // Main sequence: reset, directed checks, then random phases under each idling mix.
  initial begin
    tracker        = new();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    cycle_limit    = 20000;
    items_sent     = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_BASE_ADDRESS;
    cfg_wdata_i    = '0;
    in_bus.valid   = 1'b0;
    in_bus.mode    = MODE_ALLOC;
    in_bus.free_address = '0;
    out_bus.ready  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset layout: empty stack, address zero, pool edges, unknown mode, free with nothing used.
    send_item(MODE_ALLOC, 32'hFFFF_FFFF);
    send_item(MODE_FREE, 32'h0000_0000);
    send_item(MODE_FREE, 32'h0000_FFFF);
    send_item(MODE_FREE, 32'h0001_0000);
    send_item(MODE_FREE, 32'hFFFF_FFFF);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_NONE, 32'hA5A5_5A5A);
    send_item(MODE_FREE, 32'h0000_0040);
    drain();

    // Pool near the top of the address space with 65536-byte blocks: refill wraps around.
    apply_config(32'hFFFF_FF00, 32'd65536, 32'hFFFF_FFFF, 32'd3);
    send_item(MODE_REFILL, 32'h0);
    send_item(MODE_FREE, 32'hFFFF_FF00);
    repeat (4) send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_FREE, 32'h0000_FF00);
    send_item(MODE_FREE, 32'hFFFF_FFFF);
    send_item(MODE_NONE, 32'h0);
    drain();

    // A block count of zero gives an empty but accepted refill.
    apply_config(32'd0, 32'd1, 32'd1, 32'd0);
    send_item(MODE_REFILL, 32'h0);
    send_item(MODE_FREE, 32'h0);
    drain();

    // A block count above the stack depth saturates at the full depth.
    apply_config(32'h0000_1000, 32'd16, 32'd16384, 32'd2047);
    send_item(MODE_REFILL, 32'h0);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_FREE, tracker.handed_out[0]);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 31; recv_stall_pct = 31; end
      endcase
      phase_config(phase);
      send_item(MODE_REFILL, $urandom);
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        // Halfway through, hold off until the block has answered everything.
        if (n == PHASE_ITEMS / 2) drain();
        random_item();
      end
      drain();
    end

    repeat (32) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d replies over %0d random phases.",
             items_sent, tracker.replies_checked, NUM_PHASES);
    $display("Allocations %0d ok / %0d failed, frees %0d ok / %0d refused, %0d refills, %0d other.",
             tracker.n_alloc_ok, tracker.n_alloc_fail, tracker.n_free_ok,
             tracker.n_free_refused, tracker.n_refill, tracker.n_unknown);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
